>>> rtl/core/wbc_pkg.sv
// ----------------------------------------------------------------------------
// Window blind controller package
// Field widths, key and setting codes, drive times, scaling constants and
// the types shared by the controller, the datapath and the channel interfaces.
// ----------------------------------------------------------------------------
package wbc_pkg;

	// Number of conversions that each light sum holds.
	localparam int READINGS_AVERAGED = 5;

	// Field widths.
	localparam int SUM_W     = 13;
	localparam int ECHO_W    = 16;
	localparam int KEY_W     = 3;
	localparam int LEVEL_W   = 7;
	localparam int TIME_W    = 10;
	localparam int SET_W     = 2;
	localparam int CFG_IDX_W = 2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_DARK_LEVEL      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTER_MARGIN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MANUAL_STEP     = 2'd2;

	// Configuration reset values.
	localparam logic [LEVEL_W-1:0] DARK_LEVEL_RST      = 7'd10;
	localparam logic [LEVEL_W-1:0] BRIGHTER_MARGIN_RST = 7'd10;
	localparam logic [LEVEL_W-1:0] MANUAL_STEP_RST     = 7'd20;

	// Key codes.
	localparam logic [KEY_W-1:0] KEY_NONE      = 3'd0;
	localparam logic [KEY_W-1:0] KEY_BRIGHTEN  = 3'd1;
	localparam logic [KEY_W-1:0] KEY_STEP_UP   = 3'd2;
	localparam logic [KEY_W-1:0] KEY_DARKEN    = 3'd4;
	localparam logic [KEY_W-1:0] KEY_STEP_DOWN = 3'd5;

	// Setting codes shown to the user.
	localparam logic [SET_W-1:0] SET_NONE     = 2'd0;
	localparam logic [SET_W-1:0] SET_BRIGHTEN = 2'd1;
	localparam logic [SET_W-1:0] SET_DARKEN   = 2'd2;
	localparam logic [SET_W-1:0] SET_MANUAL   = 2'd3;

	// Drive times in 0.1 ms units.
	localparam logic [TIME_W-1:0] TIME_NONE       = 10'd0;
	localparam logic [TIME_W-1:0] TIME_OPEN_DAY   = 10'd800;
	localparam logic [TIME_W-1:0] TIME_CLOSE      = 10'd300;
	localparam logic [TIME_W-1:0] TIME_OPEN_NIGHT = 10'd600;
	localparam logic [TIME_W-1:0] TIME_STEP_UP    = 10'd700;
	localparam logic [TIME_W-1:0] TIME_STEP_DOWN  = 10'd150;

	// Scaled range limits.
	localparam int LEVEL_MAX = 100;
	localparam int POS_LOW   = 2;
	localparam int POS_HIGH  = 98;

	// Averaging: floor(sum / READINGS_AVERAGED) by reciprocal multiply.
	localparam int AVG_SHIFT   = 17;
	localparam int AVG_RECIP   = ((1 << AVG_SHIFT) + READINGS_AVERAGED - 1) / READINGS_AVERAGED;
	localparam int AVG_RECIP_W = 18;

	// Light: 100 - (avg - 50) * 100 / 900, the span reduces to a divide by 9.
	localparam int LIGHT_OFFSET = 50;
	localparam int LIGHT_DIV    = (950 - 50) / 100;
	localparam int DIV_SHIFT    = 17;
	localparam int DIV_RECIP    = ((1 << DIV_SHIFT) + LIGHT_DIV - 1) / LIGHT_DIV;
	localparam int DIV_RECIP_W  = 14;
	localparam int QUOT_W       = 10;

	// Echo to millimeters: floor(echo * 17 / 100).
	localparam int ECHO17_W    = ECHO_W + 5;
	localparam int MM_DIV      = 100;
	localparam int MM_SHIFT    = 28;
	localparam int MM_RECIP    = ((1 << MM_SHIFT) + MM_DIV - 1) / MM_DIV;
	localparam int MM_RECIP_W  = 22;
	localparam int MM_W        = 14;

	// Position: (mm - 40) * 100 / 85, reduced to (mm - 40) * 20 / 17.
	localparam int MM_OFFSET   = 40;
	localparam int POS_SPAN    = 125 - 40;
	localparam int POS_DIV     = POS_SPAN / 5;
	localparam int PM_W        = MM_W + 5;
	localparam int POS_SHIFT   = 23;
	localparam int POS_RECIP   = ((1 << POS_SHIFT) + POS_DIV - 1) / POS_DIV;
	localparam int POS_RECIP_W = 19;
	localparam int P_W         = 15;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCALE,
		ST_DIVIDE,
		ST_POSITION,
		ST_DECIDE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic scale;
		logic divide;
		logic position;
		logic commit;
	} wbc_cmd_t;

endpackage

>>> rtl/core/wbc_if.sv
// ----------------------------------------------------------------------------
// Window blind controller channel interfaces
// Sensor request channel, result channel and configuration write channel.
// ----------------------------------------------------------------------------
interface wbc_in_if;
	import wbc_pkg::*;

	logic               valid;
	logic               ready;
	logic [SUM_W-1:0]   in_light_sum;
	logic [SUM_W-1:0]   out_light_sum;
	logic [ECHO_W-1:0]  echo_time;
	logic [KEY_W-1:0]   key_code;

	modport source (output valid, output in_light_sum, output out_light_sum,
		output echo_time, output key_code, input ready);
	modport sink (input valid, input in_light_sum, input out_light_sum,
		input echo_time, input key_code, output ready);
endinterface

interface wbc_out_if;
	import wbc_pkg::*;

	logic               valid;
	logic               ready;
	logic               drive_direction;
	logic [TIME_W-1:0]  drive_time;
	logic               motor_on_after;
	logic [SET_W-1:0]   setting_code;
	logic [LEVEL_W-1:0] position;
	logic [LEVEL_W-1:0] inside_light;
	logic [LEVEL_W-1:0] outside_light;

	modport source (output valid, output drive_direction, output drive_time,
		output motor_on_after, output setting_code, output position,
		output inside_light, output outside_light, input ready);
	modport sink (input valid, input drive_direction, input drive_time,
		input motor_on_after, input setting_code, input position,
		input inside_light, input outside_light, output ready);
endinterface

interface wbc_cfg_if;
	import wbc_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [LEVEL_W-1:0]   data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/wbc_ctrl.sv
// ----------------------------------------------------------------------------
// Window blind controller sequencer
// Steps one request through scale, divide, position and decide, and owns the
// result valid flag.
// ----------------------------------------------------------------------------
module wbc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output wbc_pkg::wbc_cmd_t cmd
);
	import wbc_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_SCALE;
				end
			end
			ST_SCALE:    state_d = ST_DIVIDE;
			ST_DIVIDE:   state_d = ST_POSITION;
			ST_POSITION: state_d = ST_DECIDE;
			ST_DECIDE: begin
				if (slot_free) begin
					state_d = in_valid ? ST_SCALE : ST_IDLE;
				end
			end
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready     = 1'b0;
		cmd          = '0;
		case (state_q)
			ST_IDLE:     in_ready = 1'b1;
			ST_SCALE:    cmd.scale = 1'b1;
			ST_DIVIDE:   cmd.divide = 1'b1;
			ST_POSITION: cmd.position = 1'b1;
			ST_DECIDE: begin
				in_ready   = slot_free;
				cmd.commit = slot_free;
			end
			default:     in_ready = 1'b0;
		endcase
		cmd.load = in_valid && in_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_scale_then_divide: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCALE |=> state_q == ST_DIVIDE)
		else $error("scale step not followed by divide step");
	a_commit_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid_q)
		else $error("committed result not presented");
	a_load_starts_work: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == ST_SCALE)
		else $error("accepted request did not start scaling");
	a_one_step: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.scale, cmd.divide, cmd.position, cmd.commit}))
		else $error("more than one datapath step active");
`endif

endmodule

>>> rtl/core/wbc_datapath.sv
// ----------------------------------------------------------------------------
// Window blind controller datapath
// Sensor scaling by reciprocal multiplies, mode decision, mode state,
// configuration registers and the result register.
// ----------------------------------------------------------------------------
module wbc_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  wbc_pkg::wbc_cmd_t             cmd,
	input  logic                          cfg_we,
	input  logic [wbc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [wbc_pkg::LEVEL_W-1:0]   cfg_data,
	input  logic [wbc_pkg::SUM_W-1:0]     in_light_sum,
	input  logic [wbc_pkg::SUM_W-1:0]     out_light_sum,
	input  logic [wbc_pkg::ECHO_W-1:0]    echo_time,
	input  logic [wbc_pkg::KEY_W-1:0]     key_code,
	output logic                          drive_direction,
	output logic [wbc_pkg::TIME_W-1:0]    drive_time,
	output logic                          motor_on_after,
	output logic [wbc_pkg::SET_W-1:0]     setting_code,
	output logic [wbc_pkg::LEVEL_W-1:0]   position,
	output logic [wbc_pkg::LEVEL_W-1:0]   inside_light,
	output logic [wbc_pkg::LEVEL_W-1:0]   outside_light
);
	import wbc_pkg::*;

	// Configuration.
	logic [LEVEL_W-1:0] dark_level_q;
	logic [LEVEL_W-1:0] brighter_margin_q;
	logic [LEVEL_W-1:0] manual_step_q;

	// Captured request.
	logic [SUM_W-1:0]  in_sum_q;
	logic [SUM_W-1:0]  out_sum_q;
	logic [ECHO_W-1:0] echo_q;
	logic [KEY_W-1:0]  key_q;

	// Stage registers.
	logic [SUM_W-1:0]    avg_in_s1, avg_out_s1;
	logic [ECHO17_W-1:0] echo17_s1;
	logic                dim_in_s2, dim_out_s2;
	logic [QUOT_W-1:0]   quot_in_s2, quot_out_s2;
	logic [MM_W-1:0]     mm_s2;
	logic [LEVEL_W-1:0]  inl_s3, outl_s3;
	logic                near_s3;
	logic [P_W-1:0]      p_s3;

	// Mode state.
	logic [KEY_W-1:0]   active_key_q;
	logic [SET_W-1:0]   shown_setting_q;
	logic               step_done_q;
	logic [LEVEL_W-1:0] step_start_q;
	logic               motor_running_q;
	logic               last_direction_q;

	// Scale step products.
	logic [SUM_W+AVG_RECIP_W-1:0] avg_in_prod, avg_out_prod;
	logic [ECHO17_W-1:0]          echo17;

	// Divide step.
	logic [SUM_W-1:0]              dif_in, dif_out;
	logic [SUM_W+DIV_RECIP_W-1:0]  quot_in_prod, quot_out_prod;
	logic [ECHO17_W+MM_RECIP_W-1:0] mm_prod;

	// Position step.
	logic [MM_W-1:0]               mm_off;
	logic [PM_W-1:0]               pm;
	logic [PM_W+POS_RECIP_W-1:0]   p_prod;
	logic [LEVEL_W-1:0]            inl_d, outl_d;

	// Decision.
	logic [LEVEL_W-1:0] pos;
	logic [KEY_W-1:0]   key_d;
	logic [SET_W-1:0]   set_d;
	logic               done_d;
	logic [LEVEL_W-1:0] start_d;
	logic [LEVEL_W-1:0] start_sel;
	logic               motor_d;
	logic               dir_d;
	logic [TIME_W-1:0]  time_d;

	function automatic logic [LEVEL_W-1:0] light_level(input logic dim,
		input logic [QUOT_W-1:0] quot);
		logic [LEVEL_W-1:0] lvl;
		if (dim) begin
			lvl = LEVEL_W'(LEVEL_MAX);
		end else if (quot >= QUOT_W'(LEVEL_MAX)) begin
			lvl = '0;
		end else begin
			lvl = LEVEL_W'(QUOT_W'(LEVEL_MAX) - quot);
		end
		return lvl;
	endfunction

	// Scale: averages and echo times 17.
	assign avg_in_prod  = (SUM_W+AVG_RECIP_W)'(in_sum_q) * AVG_RECIP_W'(AVG_RECIP);
	assign avg_out_prod = (SUM_W+AVG_RECIP_W)'(out_sum_q) * AVG_RECIP_W'(AVG_RECIP);
	assign echo17       = {echo_q, 4'b0000} + ECHO17_W'(echo_q);

	// Divide: light quotients by 9 and millimeters by 100.
	assign dif_in  = avg_in_s1 - SUM_W'(LIGHT_OFFSET);
	assign dif_out = avg_out_s1 - SUM_W'(LIGHT_OFFSET);
	assign quot_in_prod  = (SUM_W+DIV_RECIP_W)'(dif_in) * DIV_RECIP_W'(DIV_RECIP);
	assign quot_out_prod = (SUM_W+DIV_RECIP_W)'(dif_out) * DIV_RECIP_W'(DIV_RECIP);
	assign mm_prod = (ECHO17_W+MM_RECIP_W)'(echo17_s1) * MM_RECIP_W'(MM_RECIP);

	// Position: (mm - 40) * 20 / 17.
	assign mm_off = mm_s2 - MM_W'(MM_OFFSET);
	assign pm     = {mm_off, 4'b0000} + {1'b0, mm_off, 2'b00};
	assign p_prod = (PM_W+POS_RECIP_W)'(pm) * POS_RECIP_W'(POS_RECIP);
	assign inl_d  = light_level(dim_in_s2, quot_in_s2);
	assign outl_d = light_level(dim_out_s2, quot_out_s2);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			in_sum_q  <= in_light_sum;
			out_sum_q <= out_light_sum;
			echo_q    <= echo_time;
			key_q     <= key_code;
		end
		if (cmd.scale) begin
			avg_in_s1  <= avg_in_prod[AVG_SHIFT +: SUM_W];
			avg_out_s1 <= avg_out_prod[AVG_SHIFT +: SUM_W];
			echo17_s1  <= echo17;
		end
		if (cmd.divide) begin
			dim_in_s2   <= avg_in_s1 <= SUM_W'(LIGHT_OFFSET);
			dim_out_s2  <= avg_out_s1 <= SUM_W'(LIGHT_OFFSET);
			quot_in_s2  <= quot_in_prod[DIV_SHIFT +: QUOT_W];
			quot_out_s2 <= quot_out_prod[DIV_SHIFT +: QUOT_W];
			mm_s2       <= mm_prod[MM_SHIFT +: MM_W];
		end
		if (cmd.position) begin
			inl_s3  <= inl_d;
			outl_s3 <= outl_d;
			near_s3 <= mm_s2 < MM_W'(MM_OFFSET);
			p_s3    <= p_prod[POS_SHIFT +: P_W];
		end
	end

	// Position clamp: readings near either end snap to closed or open.
	always_comb begin
		if (near_s3 || p_s3 <= P_W'(POS_LOW)) begin
			pos = '0;
		end else if (p_s3 >= P_W'(POS_HIGH)) begin
			pos = LEVEL_W'(LEVEL_MAX);
		end else begin
			pos = p_s3[LEVEL_W-1:0];
		end
	end

	// Mode decision.
	always_comb begin
		key_d   = active_key_q;
		if (key_q == KEY_BRIGHTEN || key_q == KEY_STEP_UP || key_q == KEY_DARKEN ||
			key_q == KEY_STEP_DOWN) begin
			key_d = key_q;
		end
		set_d     = shown_setting_q;
		done_d    = step_done_q;
		start_d   = step_start_q;
		motor_d   = motor_running_q;
		dir_d     = last_direction_q;
		time_d    = TIME_NONE;
		start_sel = step_done_q ? pos : step_start_q;
		case (key_d)
			KEY_BRIGHTEN: set_d = SET_BRIGHTEN;
			KEY_DARKEN:   set_d = SET_DARKEN;
			KEY_STEP_UP:  set_d = SET_MANUAL;
			KEY_STEP_DOWN: set_d = SET_MANUAL;
			default:      set_d = shown_setting_q;
		endcase
		case (key_d)
			KEY_BRIGHTEN: begin
				if (outl_s3 < dark_level_q) begin
					if (pos != '0) begin
						dir_d = 1'b0; time_d = TIME_CLOSE; motor_d = 1'b0;
					end
				end else if ({1'b0, outl_s3} > {1'b0, inl_s3} + {1'b0, brighter_margin_q}) begin
					if (pos < LEVEL_W'(LEVEL_MAX)) begin
						dir_d = 1'b1; time_d = TIME_OPEN_DAY; motor_d = 1'b1;
					end
				end else begin
					motor_d = 1'b0;
				end
			end
			KEY_DARKEN: begin
				if (outl_s3 > dark_level_q) begin
					if (pos != '0) begin
						dir_d = 1'b0; time_d = TIME_CLOSE; motor_d = 1'b0;
					end
				end else if (pos < LEVEL_W'(LEVEL_MAX)) begin
					dir_d = 1'b1; time_d = TIME_OPEN_NIGHT; motor_d = 1'b1;
				end
			end
			KEY_STEP_UP: begin
				if (step_done_q) begin
					start_d = pos; done_d = 1'b0;
				end
				if ({1'b0, pos} < {1'b0, start_sel} + {1'b0, manual_step_q} &&
					pos < LEVEL_W'(LEVEL_MAX)) begin
					dir_d = 1'b1; time_d = TIME_STEP_UP; motor_d = 1'b1;
				end else begin
					motor_d = 1'b0; done_d = 1'b1; key_d = KEY_NONE;
				end
			end
			KEY_STEP_DOWN: begin
				if (step_done_q) begin
					start_d = pos; done_d = 1'b0;
				end
				if ({1'b0, pos} + {1'b0, manual_step_q} > {1'b0, start_sel} && pos != '0) begin
					dir_d = 1'b0; time_d = TIME_STEP_DOWN; motor_d = 1'b0;
				end else begin
					done_d = 1'b1; key_d = KEY_NONE;
				end
			end
			default: time_d = TIME_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dark_level_q      <= DARK_LEVEL_RST;
			brighter_margin_q <= BRIGHTER_MARGIN_RST;
			manual_step_q     <= MANUAL_STEP_RST;
			active_key_q      <= KEY_NONE;
			shown_setting_q   <= SET_NONE;
			step_done_q       <= 1'b1;
			step_start_q      <= '0;
			motor_running_q   <= 1'b0;
			last_direction_q  <= 1'b1;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_DARK_LEVEL:      dark_level_q <= cfg_data;
					CFG_BRIGHTER_MARGIN: brighter_margin_q <= cfg_data;
					CFG_MANUAL_STEP:     manual_step_q <= cfg_data;
					default:             manual_step_q <= manual_step_q;
				endcase
			end
			if (cmd.commit) begin
				active_key_q     <= key_d;
				shown_setting_q  <= set_d;
				step_done_q      <= done_d;
				step_start_q     <= start_d;
				motor_running_q  <= motor_d;
				last_direction_q <= dir_d;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			drive_direction <= dir_d;
			drive_time      <= time_d;
			motor_on_after  <= motor_d;
			setting_code    <= set_d;
			position        <= pos;
			inside_light    <= inl_s3;
			outside_light   <= outl_s3;
		end
	end

endmodule

>>> rtl/core/window_blind_controller.sv
// ----------------------------------------------------------------------------
// Window blind controller
// Scales light and echo readings and decides the blind motor drive per request.
// ----------------------------------------------------------------------------
// Usage:
// The sensor channel carries one request per control pass: the inside and
// outside light sums, the ultrasonic echo time and an optional key. Every
// request produces exactly one result on the result channel, with drive
// direction, drive time, motor state, setting code and the scaled position
// and light values. Both channels use valid/ready; a request moves at a clock
// edge where both are high. The cfg channel writes dark level, brighter
// margin and manual step by index; it is always ready and is meant to be
// written only while no request is in flight.
// A new request is taken in the cycle the previous result is committed, so
// each request goes through the scale, divide, position and decide steps of
// the sequencer before the next one starts. The result sits in an output
// register; while the receiver stalls one further request is worked up to
// the decide step and then waits there. Reset clears the mode to none, marks
// the manual step as done, sets the last direction to opening and loads the
// register defaults.
// ----------------------------------------------------------------------------
module window_blind_controller (
	input  logic      clk,
	input  logic      arst_n,
	wbc_in_if.sink    sensor,
	wbc_out_if.source result,
	wbc_cfg_if.sink   cfg
);
	import wbc_pkg::*;

	wbc_cmd_t cmd;
	logic     in_ready;
	logic     out_valid;

	// The configuration registers take a write in any cycle.
	assign cfg.ready = 1'b1;

	assign sensor.ready = in_ready;
	assign result.valid = out_valid;

	// The sequencer steps each request through the datapath and holds the
	// result valid flag until the receiver takes the result.
	wbc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sensor.valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (result.ready),
		.cmd       (cmd)
	);

	// The datapath holds the scaling stages, the mode state, the
	// configuration registers and the result register.
	wbc_datapath u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.cfg_we          (cfg.valid),
		.cfg_index       (cfg.index),
		.cfg_data        (cfg.data),
		.in_light_sum    (sensor.in_light_sum),
		.out_light_sum   (sensor.out_light_sum),
		.echo_time       (sensor.echo_time),
		.key_code        (sensor.key_code),
		.drive_direction (result.drive_direction),
		.drive_time      (result.drive_time),
		.motor_on_after  (result.motor_on_after),
		.setting_code    (result.setting_code),
		.position        (result.position),
		.inside_light    (result.inside_light),
		.outside_light   (result.outside_light)
	);

endmodule
